// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds -> expr holds in the same cycle
`define SPN_ASSERT_IMPL(name, clk, rst_n, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// cond holds -> expr holds in the next cycle
`define SPN_ASSERT_NEXT(name, clk, rst_n, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== design/spn_pkg.sv =====
// ----------------------------------------------------------------------------
// spn_pkg
// shared types, constants and arithmetic helpers of the peak normalizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spn_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned DataW     = 2 * SampleW;
  localparam int unsigned LevelW    = 7;
  localparam int unsigned GainW     = 32;
  localparam int unsigned GainFracW = 16;
  // dividend is level * 2^31
  localparam int unsigned NumW      = LevelW + 31;
  localparam int unsigned PeakW     = SampleW + 1;
  // 100 * 32768 stays below 2^22
  localparam int unsigned DenW      = PeakW + 5;
  localparam int unsigned ProdW     = SampleW + GainW;

  typedef enum logic [1:0] {
    OpBeginMeasure = 2'd0,
    OpMeasure      = 2'd1,
    OpBeginApply   = 2'd2,
    OpApply        = 2'd3
  } op_e;

  typedef enum logic {
    RegLevel  = 1'b0,
    RegStereo = 1'b1
  } reg_idx_e;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    op_e     op;
    sample_t left;
    sample_t right;
  } cmd_t;

  // 100 * max(-min, max), min <= 0 <= max
  function automatic logic [DenW-1:0] peak_den(sample_t mn, sample_t mx);
    logic [PeakW-1:0] neg_mn;
    logic [PeakW-1:0] pos_mx;
    logic [PeakW-1:0] peak;
    logic [DenW-1:0]  pk;
    neg_mn = ~{mn[SampleW-1], mn} + PeakW'(1);
    pos_mx = {mx[SampleW-1], mx};
    peak   = (neg_mn > pos_mx) ? neg_mn : pos_mx;
    pk     = DenW'(peak);
    return (pk << 6) + (pk << 5) + (pk << 2);
  endfunction

  // floor shift by the gain fraction, then clamp to the sample range
  function automatic sample_t scale_sat(logic signed [ProdW-1:0] p);
    logic [ProdW-GainFracW-1:0] hi;
    logic                       in_range;
    hi       = p[ProdW-1:GainFracW];
    in_range = (hi[ProdW-GainFracW-1:SampleW-1] == '0) ||
               (hi[ProdW-GainFracW-1:SampleW-1] == '1);
    if (in_range) begin
      return hi[SampleW-1:0];
    end else if (hi[ProdW-GainFracW-1]) begin
      return {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      return {1'b0, {(SampleW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/spn_front.sv =====
// ----------------------------------------------------------------------------
// spn_front
// input stage: takes stream transactions, decodes the operation, feeds queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spn_front import spn_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [DataW-1:0] in_data_i,   // left_sample, right_sample
  input  wire logic [1:0]       in_user_i,   // operation
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output cmd_t                  cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic take;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q.op    <= op_e'(in_user_i);
      cmd_q.left  <= in_data_i[SampleW-1:0];
      cmd_q.right <= in_data_i[DataW-1:SampleW];
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

// ===== design/spn_queue.sv =====
// ----------------------------------------------------------------------------
// spn_queue
// small command fifo between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spn_queue import spn_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/spn_div.sv =====
// ----------------------------------------------------------------------------
// spn_div
// restoring divider, one quotient bit per cycle, for the gain computation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spn_div import spn_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [GainW-1:0]     quot_o
);

  localparam int unsigned CntW = $clog2(NumW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q, rem_d;
  logic [GainW-1:0] quot_q, quot_d;
  logic [DenW:0]    trial;
  logic [DenW:0]    diff;
  logic             fits;
  logic             last;

  assign trial = {rem_q, num_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});
  assign last  = (cnt_q == CntW'(NumW - 1));
  // quotient is known to fit the gain width, upper bits drop off the shift
  assign rem_d  = fits ? diff[DenW-1:0] : trial[DenW-1:0];
  assign quot_d = {quot_q[GainW-2:0], fits};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= num_q << 1;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== design/spn_back.sv =====
// ----------------------------------------------------------------------------
// spn_back
// execution side: peak tracking, gain division and the scaling pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spn_back import spn_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire cmd_t              cmd_i,
  input  wire logic [LevelW-1:0] level_i,
  input  wire logic              stereo_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [DataW-1:0]       out_data_o   // left_out, right_out
);

  typedef enum logic [2:0] {
    StIdle     = 3'b001,
    StDivLeft  = 3'b010,
    StDivRight = 3'b100
  } state_e;

  state_e  state_q, state_d;
  sample_t lmin_q, lmax_q, rmin_q, rmax_q;
  logic [GainW-1:0] lgain_q, rgain_q;

  logic                    en, idle, pop, is_apply, is_begin_apply;
  logic                    div_start, div_busy, div_done;
  logic [DenW-1:0]         lden, rden, div_den;
  logic [GainW-1:0]        div_quot;
  logic                    lzero, rzero;
  logic signed [ProdW:0]   mul_l, mul_r;

  logic                    prod_valid_q;
  logic signed [ProdW-1:0] prod_l_q, prod_r_q;
  logic                    r_on_q;
  logic                    out_valid_q;
  sample_t                 out_l_q, out_r_q;

  // pipeline moves when the output register is free or drains this cycle
  assign en             = !out_valid_q || out_ready_i;
  assign idle           = (state_q == StIdle);
  assign cmd_ready_o    = idle && en;
  assign pop            = cmd_valid_i && cmd_ready_o;
  assign is_apply       = (cmd_i.op == OpApply);
  assign is_begin_apply = (cmd_i.op == OpBeginApply);

  // extremes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lmin_q <= '0;
      lmax_q <= '0;
      rmin_q <= '0;
      rmax_q <= '0;
    end else if (pop) begin
      unique case (cmd_i.op)
        OpBeginMeasure: begin
          lmin_q <= '0;
          lmax_q <= '0;
          rmin_q <= '0;
          rmax_q <= '0;
        end
        OpMeasure: begin
          if (cmd_i.left < lmin_q) lmin_q <= cmd_i.left;
          if (cmd_i.left > lmax_q) lmax_q <= cmd_i.left;
          if (stereo_i) begin
            if (cmd_i.right < rmin_q) rmin_q <= cmd_i.right;
            if (cmd_i.right > rmax_q) rmax_q <= cmd_i.right;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // gain division, left then right through the shared divider
  assign lden      = peak_den(lmin_q, lmax_q);
  assign rden      = peak_den(rmin_q, rmax_q);
  assign lzero     = (lmin_q == '0) && (lmax_q == '0);
  assign rzero     = (rmin_q == '0) && (rmax_q == '0);
  assign div_den   = idle ? lden : rden;
  assign div_start = (pop && is_begin_apply) || (div_done && (state_q == StDivLeft));

  spn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({level_i, 31'b0}),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:     if (pop && is_begin_apply) state_d = StDivLeft;
      StDivLeft:  if (div_done) state_d = StDivRight;
      StDivRight: if (div_done) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lgain_q <= '0;
      rgain_q <= '0;
    end else begin
      state_q <= state_d;
      if (div_done && (state_q == StDivLeft)) begin
        lgain_q <= lzero ? '0 : div_quot;
      end
      if (div_done && (state_q == StDivRight)) begin
        rgain_q <= rzero ? '0 : div_quot;
      end
    end
  end

  // scaling: multiply stage, then shift and clamp into the output register
  assign mul_l = (ProdW+1)'(cmd_i.left)  * (ProdW+1)'($signed({1'b0, lgain_q}));
  assign mul_r = (ProdW+1)'(cmd_i.right) * (ProdW+1)'($signed({1'b0, rgain_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (en) begin
      prod_valid_q <= pop && is_apply;
      out_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && is_apply) begin
      prod_l_q <= mul_l[ProdW-1:0];
      prod_r_q <= mul_r[ProdW-1:0];
      r_on_q   <= stereo_i;
    end
    if (en && prod_valid_q) begin
      out_l_q <= scale_sat(prod_l_q);
      out_r_q <= r_on_q ? scale_sat(prod_r_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_r_q, out_l_q};

  `SPN_ASSERT_IMPL(a_no_pop_in_div, clk_i, rst_ni, !idle, !pop, "command taken during division")
  `SPN_ASSERT_IMPL(a_div_start_free, clk_i, rst_ni, div_start, !div_busy, "divider restarted")
  `SPN_ASSERT_NEXT(a_stage_adv, clk_i, rst_ni, prod_valid_q && en, out_valid_q, "product lost")

endmodule

`default_nettype wire

// ===== design/stereo_peak_normalizer.sv =====
// ----------------------------------------------------------------------------
// stereo_peak_normalizer
// two-pass peak normalizer for Q1.15 stereo frames
//
// input stream: tuser carries the operation (begin measure, measure frame,
// begin apply, apply frame), tdata carries the left and right samples.
// output stream: one transaction per apply frame with the scaled samples,
// right channel zero in mono mode. other operations give no output.
// config channel: index 0 level percent, index 1 stereo mode; write only
// while the block is idle. cfg_ready_o is always high.
// an apply frame reaches the output through the input register, the queue
// write, the multiply stage and the clamp stage. the input and the back end
// take one frame per cycle while nothing stalls; begin apply holds the back
// end while the bit-serial divider produces the left and then the right
// gain, one quotient bit per cycle over 38 bits.
// the command queue lets the input keep flowing until it fills.
// reset clears extremes and gains to zero, level to 100, stereo mode on.
// when the receiver stalls the output register holds its transaction and
// the stall backs up through the pipeline, the queue and the input stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_peak_normalizer import spn_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DataW-1:0]  s_axis_tdata,   // left_sample, right_sample
  input  wire logic [1:0]        s_axis_tuser,   // operation
  // output stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DataW-1:0]       m_axis_tdata,   // left_out, right_out
  // configuration writes
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_addr_i,
  input  wire logic [LevelW-1:0] cfg_data_i
);

  logic [LevelW-1:0] level_q;
  logic              stereo_q;
  logic              cfg_we;

  // front to queue, queue to back
  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= LevelW'(100);
      stereo_q <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(cfg_addr_i))
        RegLevel:  level_q  <= cfg_data_i;
        RegStereo: stereo_q <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  // accept and decode
  spn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .cmd_valid_o(fq_valid),
    .cmd_ready_i(fq_ready),
    .cmd_o      (fq_cmd)
  );

  // decoupling queue
  spn_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_cmd_i  (fq_cmd),
    .pop_valid_o (qb_valid),
    .pop_ready_i (qb_ready),
    .pop_cmd_o   (qb_cmd)
  );

  // extremes, gains and scaling
  spn_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(qb_valid),
    .cmd_ready_o(qb_ready),
    .cmd_i      (qb_cmd),
    .level_i    (level_q),
    .stereo_i   (stereo_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stereo peak normalizer
//
// drives measure and apply passes into the input stream, writes level and
// stereo mode between passes, and checks every scaled output frame against
// a bit-exact predictor of the gain division and the saturating multiply.
// both stream sides idle at random; one pass holds the receiver off long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import spn_pkg::*;

  // begin apply runs the divider with no output
  localparam int SettleCycles = 100;
  // longest quiet stretch: receiver hold, divider, settle pause, long gaps
  localparam int IdleLimit    = 4000;
  localparam int HoldCycles   = 400;

  // scoreboard: tracks extremes and gains, queues expected scaled frames
  class norm_scoreboard;
    bit [LevelW-1:0] level;
    bit              stereo;
    sample_t         left_min, left_max, right_min, right_max;
    bit [GainW-1:0]  left_gain, right_gain;
    logic [DataW-1:0] scaled_q[$];
    int              mismatches;

    function new();
      level      = 7'd100;
      stereo     = 1'b1;
      left_min   = '0;
      left_max   = '0;
      right_min  = '0;
      right_max  = '0;
      left_gain  = '0;
      right_gain = '0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, bit [LevelW-1:0] value);
      if (idx == RegLevel) begin
        level = value;
      end else begin
        stereo = value[0];
      end
    endfunction

    // floor(level * 2^31 / (100 * peak)), zero when nothing was measured
    function bit [GainW-1:0] gain_from_extremes(sample_t mn, sample_t mx);
      longint peak;
      longint unsigned num;
      if (mn == 0 && mx == 0) return '0;
      peak = -longint'(mn);
      if (longint'(mx) > peak) peak = mx;
      num = longint'(level) << 31;
      return GainW'(num / (100 * peak));
    endfunction

    // sample times Q16.16 gain, floor shift, clamp to Q1.15
    function sample_t scale_sample(sample_t s, bit [GainW-1:0] g);
      longint sl, gl, q;
      sl = s;
      gl = g;
      q  = (sl * gl) >>> GainFracW;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return sample_t'(q[SampleW-1:0]);
    endfunction

    function void take_frame(op_e op, sample_t l, sample_t r);
      sample_t lo, ro;
      case (op)
        OpBeginMeasure: begin
          left_min  = '0;
          left_max  = '0;
          right_min = '0;
          right_max = '0;
        end
        OpMeasure: begin
          if (l < left_min) left_min = l;
          if (l > left_max) left_max = l;
          if (stereo) begin
            if (r < right_min) right_min = r;
            if (r > right_max) right_max = r;
          end
        end
        OpBeginApply: begin
          left_gain  = gain_from_extremes(left_min, left_max);
          right_gain = gain_from_extremes(right_min, right_max);
        end
        default: begin
          lo = scale_sample(l, left_gain);
          ro = stereo ? scale_sample(r, right_gain) : sample_t'(0);
          scaled_q.push_back({ro, lo});
        end
      endcase
    endfunction

    function void flag(string what, logic [SampleW-1:0] want, logic [SampleW-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d got %0d", what, $signed(want), $signed(got));
    endfunction

    function void check_scaled(logic [DataW-1:0] got);
      logic [DataW-1:0] want;
      if (scaled_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output frame left %0d right %0d",
                   $signed(got[SampleW-1:0]), $signed(got[DataW-1:SampleW]));
        return;
      end
      want = scaled_q.pop_front();
      if (got[SampleW-1:0] !== want[SampleW-1:0])
        flag("left_out", want[SampleW-1:0], got[SampleW-1:0]);
      if (got[DataW-1:SampleW] !== want[DataW-1:SampleW])
        flag("right_out", want[DataW-1:SampleW], got[DataW-1:SampleW]);
    endfunction

    function int pending();
      return scaled_q.size();
    endfunction

    function void close();
      if (scaled_q.size() != 0) begin
        mismatches += scaled_q.size();
        $display("%0d expected output frames never arrived", scaled_q.size());
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic [DataW-1:0]  s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_addr = 1'b0;
  logic [LevelW-1:0] cfg_data = '0;
  wire               s_tready;
  wire               m_tvalid;
  wire [DataW-1:0]   m_tdata;
  wire               cfg_ready;

  norm_scoreboard board = new();
  bit calm = 1'b0;      // no idling on either side while set
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off
  int idle_cycles = 0;

  stereo_peak_normalizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // gap length: mostly short, sometimes medium, rarely long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // signed sample limited to the given number of bits
  function automatic sample_t rand_sample(int bits);
    int x;
    x = int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
    return sample_t'(x);
  endfunction

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    int stall_left;
    bit want;
    if (hold_req) begin
      stall_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      want = 1'b0;
    end else begin
      want = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    end
    m_tready <= want;
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) board.check_scaled(m_tdata);
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("FAIL stereo_peak_normalizer");
        $finish;
      end
    end
  end

  task automatic push_frame(op_e op, sample_t l, sample_t r);
    int gap;
    gap = (calm || $urandom_range(0, 9) < 7) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {r, l};
    do @(posedge clk_i); while (!s_tready);
    board.take_frame(op, l, r);
  endtask

  // wait for every expected frame, then let a pending gain division finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [LevelW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // random op with full-range samples
  task automatic push_noise(inout int sent);
    push_frame(op_e'($urandom_range(0, 3)), rand_sample(16), rand_sample(16));
    sent++;
  endtask

  // one measure pass and one apply pass with random content
  task automatic run_passes(inout int sent, input int n_apply);
    int lbits, rbits, n_meas;
    lbits  = $urandom_range(1, 16);
    rbits  = $urandom_range(1, 16);
    n_meas = $urandom_range(1, 12);
    if ($urandom_range(0, 9) != 0) begin
      push_frame(OpBeginMeasure, rand_sample(16), rand_sample(16));
      sent++;
    end
    repeat (n_meas) begin
      if ($urandom_range(0, 11) == 0) push_noise(sent);
      push_frame(OpMeasure, rand_sample(lbits), rand_sample(rbits));
      sent++;
    end
    if ($urandom_range(0, 9) != 0) begin
      push_frame(OpBeginApply, rand_sample(16), rand_sample(16));
      sent++;
    end
    repeat (n_apply) begin
      if ($urandom_range(0, 11) == 0) push_noise(sent);
      if ($urandom_range(0, 1) == 0) begin
        push_frame(OpApply, rand_sample(lbits), rand_sample(rbits));
      end else begin
        push_frame(OpApply, rand_sample(16), rand_sample(16));
      end
      sent++;
    end
  endtask

  task automatic run_phase(bit [LevelW-1:0] lvl, bit st, int budget, bit no_idle,
                           bit with_hold);
    int sent;
    sent = 0;
    wait_idle();
    write_reg(RegLevel, lvl);
    write_reg(RegStereo, st);
    calm = no_idle;
    if (with_hold) begin
      // receiver holds off while the sender keeps offering apply frames
      hold_req = 1'b1;
      run_passes(sent, 40);
    end
    while (sent < budget) run_passes(sent, $urandom_range(1, 16));
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // apply before any measurement: gains are zero
    push_frame(OpApply, 16'sd1234, -16'sd5678);
    // full-scale extremes on both channels
    push_frame(OpBeginMeasure, 16'sd0, 16'sd0);
    push_frame(OpMeasure, -16'sd32768, 16'sd32767);
    push_frame(OpMeasure, 16'sd32767, -16'sd32768);
    push_frame(OpBeginApply, 16'sd0, 16'sd0);
    push_frame(OpApply, -16'sd32768, 16'sd32767);
    push_frame(OpApply, 16'sd32767, -16'sd32768);
    push_frame(OpApply, 16'sd0, 16'sd0);
    push_frame(OpApply, -16'sd1, 16'sd1);
    // nothing measured: gain zero
    push_frame(OpBeginMeasure, 16'sd0, 16'sd0);
    push_frame(OpBeginApply, 16'sd0, 16'sd0);
    push_frame(OpApply, 16'sd100, -16'sd100);
    // peak of one: largest gain, outputs saturate
    push_frame(OpBeginMeasure, 16'sd0, 16'sd0);
    push_frame(OpMeasure, 16'sd1, -16'sd1);
    push_frame(OpBeginApply, 16'sd0, 16'sd0);
    push_frame(OpApply, 16'sd1, -16'sd1);
    push_frame(OpApply, -16'sd32768, 16'sd32767);
    push_frame(OpApply, -16'sd1, 16'sd0);

    // mono, lowest nonzero level
    run_phase(7'd1, 1'b0, 100, 1'b0, 1'b0);
    // level above one hundred saturates on apply
    run_phase(7'd127, 1'b1, 100, 1'b0, 1'b1);
    // level zero gives zero output
    run_phase(7'd0, 1'b1, 60, 1'b0, 1'b0);
    run_phase(7'd100, 1'b0, 100, 1'b1, 1'b0);
    run_phase(7'd100, 1'b1, 60, 1'b0, 1'b0);
    repeat (3) run_phase(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 80,
                         1'b0, 1'b0);
    run_phase(7'($urandom_range(1, 100)), 1'b1, 60, 1'b0, 1'b0);

    wait_idle();
    board.close();
    if (board.mismatches == 0) begin
      $display("PASS stereo_peak_normalizer");
    end else begin
      $display("FAIL stereo_peak_normalizer");
    end
    $finish;
  end

endmodule
